[src/mcc_pkg.sv]
// Shared types, codes and constants of the MOESI coherence controller.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package mcc_pkg;

  localparam int LINES     = 256;
  localparam int MAX_CORES = 16;
  localparam int IDX_W     = $clog2(LINES);
  localparam int WORDS_W   = 7;
  localparam int CORES_W   = 5;
  localparam int LEFT_W    = 8;
  localparam int WORDS_MAX = 64;

  localparam logic [2:0] ST_M = 3'd0;
  localparam logic [2:0] ST_O = 3'd1;
  localparam logic [2:0] ST_E = 3'd2;
  localparam logic [2:0] ST_S = 3'd3;
  localparam logic [2:0] ST_I = 3'd4;

  localparam logic [2:0] K_RD_MISS = 3'd0;
  localparam logic [2:0] K_WR_MISS = 3'd1;
  localparam logic [2:0] K_RD_HIT  = 3'd2;
  localparam logic [2:0] K_WR_HIT  = 3'd3;
  localparam logic [2:0] K_SNOOP   = 3'd4;

  localparam logic [1:0] SN_BUSRD  = 2'd0;
  localparam logic [1:0] SN_BUSRDX = 2'd1;
  localparam logic [1:0] SN_BUSINV = 2'd2;

  localparam logic [1:0] BR_NONE  = 2'd0;
  localparam logic [1:0] BR_BUSRD = 2'd1;
  localparam logic [1:0] BR_RDX   = 2'd2;
  localparam logic [1:0] BR_INV   = 2'd3;

  localparam logic REG_WORDS = 1'b0;
  localparam logic REG_CORES = 1'b1;

  typedef struct packed {
    logic [WORDS_W-1:0] words;
    logic [CORES_W-1:0] cores;
  } cfg_t;

  typedef struct packed {
    logic [2:0]       kind;
    logic [IDX_W-1:0] idx;
    logic             granted;
    logic             wb_done;
    logic             rd_done;
    logic             p_wait;
    logic             p_pres;
    logic [1:0]       stype;
    logic             s_hit;
  } item_t;

  typedef struct packed {
    logic              flushed;
    logic              pvalid;
    logic [1:0]        ptype;
    logic [IDX_W-1:0]  pline;
    logic [LEFT_W-1:0] left;
  } ctl_t;

  typedef struct packed {
    logic       done_res;
    logic [1:0] bus_request;
    logic       bus_release;
    logic [2:0] new_status;
    logic       wrote_back;
    logic       fault;
    logic       resp_present;
    logic       resp_wait;
    logic       resp_completed;
  } res_t;

endpackage

[src/mcc_status_ram.sv]
// Line status memory: one status per line, registered read, valid bit per line.
// A line never written reads as invalid. Depends on mcc_pkg.
`timescale 1ns / 1ps

module mcc_status_ram (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     rd_en,
  input  logic [mcc_pkg::IDX_W-1:0] rd_addr,
  output logic [2:0]               rd_data,
  input  logic                     wr_en,
  input  logic [mcc_pkg::IDX_W-1:0] wr_addr,
  input  logic [2:0]               wr_data
);

  logic [2:0]               mem [mcc_pkg::LINES];
  logic [mcc_pkg::LINES-1:0] vld_r;
  logic [2:0]               rd_data_r;
  logic                     rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= vld_r[rd_addr];
      end
    end
  end

  assign rd_data = rd_vld_r ? rd_data_r : mcc_pkg::ST_I;

endmodule

[src/mcc_cfg_regs.sv]
// APB-style configuration registers: words per line and core count.
// Depends on mcc_pkg.
`timescale 1ns / 1ps

module mcc_cfg_regs (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready,
  output mcc_pkg::cfg_t cfg
);

  logic [mcc_pkg::WORDS_W-1:0] words_r;
  logic [mcc_pkg::CORES_W-1:0] cores_r;
  logic                        wr_en;

  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      words_r <= mcc_pkg::WORDS_W'(8);
      cores_r <= mcc_pkg::CORES_W'(4);
    end else if (wr_en) begin
      unique case (paddr[2])
        mcc_pkg::REG_WORDS: words_r <= pwdata[mcc_pkg::WORDS_W-1:0];
        mcc_pkg::REG_CORES: cores_r <= pwdata[mcc_pkg::CORES_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      mcc_pkg::REG_WORDS: prdata = {{(32-mcc_pkg::WORDS_W){1'b0}}, words_r};
      mcc_pkg::REG_CORES: prdata = {{(32-mcc_pkg::CORES_W){1'b0}}, cores_r};
      default:            prdata = '0;
    endcase
  end

  assign cfg.words = words_r;
  assign cfg.cores = cores_r;

endmodule

[src/mcc_step.sv]
// MOESI transition logic for one item: takes the read line status and the
// control state, gives the result, the status write and the next control state.
// Depends on mcc_pkg.
`timescale 1ns / 1ps

module mcc_step (
  input  mcc_pkg::item_t item,
  input  logic [2:0]     status,
  input  mcc_pkg::ctl_t  ctl,
  input  mcc_pkg::cfg_t  cfg,
  output mcc_pkg::res_t  res,
  output logic           st_we,
  output logic [2:0]     st_data,
  output mcc_pkg::ctl_t  ctl_nxt
);

  logic [mcc_pkg::WORDS_W-1:0] w_clamp;
  logic [mcc_pkg::CORES_W-1:0] c_clamp;
  logic [mcc_pkg::LEFT_W-1:0]  xfer_len;
  logic                        proceed;
  logic                        dirty;

  always_comb begin
    if (cfg.words == '0) begin
      w_clamp = mcc_pkg::WORDS_W'(1);
    end else if (cfg.words > mcc_pkg::WORDS_W'(mcc_pkg::WORDS_MAX)) begin
      w_clamp = mcc_pkg::WORDS_W'(mcc_pkg::WORDS_MAX);
    end else begin
      w_clamp = cfg.words;
    end
    if (cfg.cores == '0) begin
      c_clamp = mcc_pkg::CORES_W'(1);
    end else if (cfg.cores > mcc_pkg::CORES_W'(mcc_pkg::MAX_CORES)) begin
      c_clamp = mcc_pkg::CORES_W'(mcc_pkg::MAX_CORES);
    end else begin
      c_clamp = cfg.cores;
    end
    xfer_len = {w_clamp, 1'b0} - mcc_pkg::LEFT_W'(1);
    if (status == mcc_pkg::ST_S) begin
      xfer_len = xfer_len + mcc_pkg::LEFT_W'(c_clamp) + mcc_pkg::LEFT_W'(1);
    end
  end

  assign dirty = (status == mcc_pkg::ST_M) || (status == mcc_pkg::ST_O);

  always_comb begin
    res     = '0;
    st_we   = 1'b0;
    st_data = status;
    ctl_nxt = ctl;
    proceed = 1'b0;
    case (item.kind)
      mcc_pkg::K_RD_MISS, mcc_pkg::K_WR_MISS: begin
        if (item.granted) begin
          proceed = 1'b1;
          if (dirty && !ctl.flushed) begin
            if (item.wb_done) begin
              ctl_nxt.flushed = 1'b1;
              res.wrote_back  = 1'b1;
            end else begin
              proceed = 1'b0;
            end
          end
          if (proceed) begin
            res.bus_request = (item.kind == mcc_pkg::K_RD_MISS) ?
                              mcc_pkg::BR_BUSRD : mcc_pkg::BR_RDX;
            if (!item.p_wait && (item.p_pres || item.rd_done)) begin
              st_we = 1'b1;
              if (item.kind == mcc_pkg::K_WR_MISS) begin
                st_data = mcc_pkg::ST_M;
              end else begin
                st_data = item.p_pres ? mcc_pkg::ST_S : mcc_pkg::ST_E;
              end
              res.done_res    = 1'b1;
              res.bus_release = 1'b1;
              ctl_nxt.flushed = 1'b0;
            end
          end
        end
      end
      mcc_pkg::K_RD_HIT: begin
        res.done_res = 1'b1;
      end
      mcc_pkg::K_WR_HIT: begin
        if (item.granted) begin
          if (status == mcc_pkg::ST_M || status == mcc_pkg::ST_E) begin
            st_we           = 1'b1;
            st_data         = mcc_pkg::ST_M;
            res.done_res    = 1'b1;
            res.bus_release = 1'b1;
            ctl_nxt.flushed = 1'b0;
          end else if (status == mcc_pkg::ST_S || status == mcc_pkg::ST_O) begin
            res.bus_request = mcc_pkg::BR_INV;
            if (!item.p_wait) begin
              st_we           = 1'b1;
              st_data         = mcc_pkg::ST_M;
              res.done_res    = 1'b1;
              res.bus_release = 1'b1;
              ctl_nxt.flushed = 1'b0;
            end
          end else begin
            res.fault = 1'b1;
          end
        end
      end
      mcc_pkg::K_SNOOP: begin
        if (ctl.pvalid) begin
          res.resp_present = 1'b1;
          if (ctl.left > mcc_pkg::LEFT_W'(1)) begin
            res.resp_wait = 1'b1;
            ctl_nxt.left  = ctl.left - mcc_pkg::LEFT_W'(1);
          end else begin
            res.resp_completed = 1'b1;
            ctl_nxt.pvalid     = 1'b0;
            ctl_nxt.left       = '0;
            st_we              = 1'b1;
            if (ctl.ptype == mcc_pkg::SN_BUSRD) begin
              if (status == mcc_pkg::ST_M) begin
                st_data = mcc_pkg::ST_O;
              end else if (status == mcc_pkg::ST_E) begin
                st_data = mcc_pkg::ST_S;
              end
            end else begin
              st_data = mcc_pkg::ST_I;
            end
          end
        end else if (item.stype == mcc_pkg::SN_BUSINV) begin
          res.resp_present = item.s_hit;
          if (item.s_hit) begin
            st_we   = 1'b1;
            st_data = mcc_pkg::ST_I;
          end
        end else if (item.stype == mcc_pkg::SN_BUSRD ||
                     item.stype == mcc_pkg::SN_BUSRDX) begin
          res.resp_present = item.s_hit;
          res.resp_wait    = item.s_hit;
          if (item.s_hit) begin
            ctl_nxt.pvalid = 1'b1;
            ctl_nxt.ptype  = item.stype;
            ctl_nxt.pline  = item.idx;
            ctl_nxt.left   = xfer_len;
          end else begin
            res.resp_completed = 1'b1;
          end
        end
      end
      default: ;
    endcase
    res.new_status = st_data;
  end

endmodule

[src/moesi_coherence_controller.sv]
// Top level of the MOESI coherence controller: handshakes, sequencing,
// control state and output register. Depends on mcc_pkg, mcc_status_ram,
// mcc_cfg_regs and mcc_step.
//
//   channel | direction | handshake          | payload
//   in_     | input     | in_valid/in_stall  | kind, line index, bus/memory/peer/snoop flags
//   out_    | output    | out_valid/out_stall| done, bus request/release, status, answers
//   cfg     | input     | psel/penable/pready| words per line, core count
//
// For each item, the accept edge issues the status memory read; the commit
// edge, when the output is free, writes the status back and loads the output register.
// Reset clears all line valid bits at once, so every line reads invalid; no sweep.
// A stalled output holds the finished item; the next item waits in the
// execute step until the output register frees.
`timescale 1ns / 1ps

module moesi_coherence_controller (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_kind,
  input  logic [7:0]  in_line_index,
  input  logic        in_bus_granted,
  input  logic        in_writeback_done,
  input  logic        in_read_done,
  input  logic        in_peer_waiting,
  input  logic        in_peer_present,
  input  logic [1:0]  in_snoop_type,
  input  logic        in_snoop_hit,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_done_res,
  output logic [1:0]  out_bus_request,
  output logic        out_bus_release,
  output logic [2:0]  out_new_status,
  output logic        out_wrote_back,
  output logic        out_fault,
  output logic        out_resp_present,
  output logic        out_resp_wait,
  output logic        out_resp_completed,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t                    state_r, state_nxt;
  mcc_pkg::item_t            item_r;
  mcc_pkg::item_t            item_in;
  mcc_pkg::ctl_t             ctl_r, ctl_step;
  mcc_pkg::res_t             res_r, res_step;
  mcc_pkg::cfg_t             cfg;
  logic [mcc_pkg::IDX_W-1:0] acted_r, rd_addr;
  logic [2:0]                rd_status;
  logic                      st_we;
  logic [2:0]                st_data;
  logic                      out_valid_r;
  logic                      accept;
  logic                      commit;

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign commit   = (state_r == S_EXEC) && (!out_valid_r || !out_stall);

  assign item_in.kind    = in_kind;
  assign item_in.idx     = in_line_index[mcc_pkg::IDX_W-1:0];
  assign item_in.granted = in_bus_granted;
  assign item_in.wb_done = in_writeback_done;
  assign item_in.rd_done = in_read_done;
  assign item_in.p_wait  = in_peer_waiting;
  assign item_in.p_pres  = in_peer_present;
  assign item_in.stype   = in_snoop_type;
  assign item_in.s_hit   = in_snoop_hit;

  assign rd_addr = (in_kind == mcc_pkg::K_SNOOP && ctl_r.pvalid) ? ctl_r.pline : item_in.idx;

  mcc_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  mcc_status_ram u_ram (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (accept),
    .rd_addr (rd_addr),
    .rd_data (rd_status),
    .wr_en   (commit && st_we),
    .wr_addr (acted_r),
    .wr_data (st_data)
  );

  mcc_step u_step (
    .item    (item_r),
    .status  (rd_status),
    .ctl     (ctl_r),
    .cfg     (cfg),
    .res     (res_step),
    .st_we   (st_we),
    .st_data (st_data),
    .ctl_nxt (ctl_step)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (accept) state_nxt = S_EXEC;
      S_EXEC: if (commit) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ctl_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (commit) begin
        ctl_r       <= ctl_step;
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r  <= item_in;
      acted_r <= rd_addr;
    end
    if (commit) begin
      res_r <= res_step;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_done_res       = res_r.done_res;
  assign out_bus_request    = res_r.bus_request;
  assign out_bus_release    = res_r.bus_release;
  assign out_new_status     = res_r.new_status;
  assign out_wrote_back     = res_r.wrote_back;
  assign out_fault          = res_r.fault;
  assign out_resp_present   = res_r.resp_present;
  assign out_resp_wait      = res_r.resp_wait;
  assign out_resp_completed = res_r.resp_completed;

  a_pend_left: assert property (@(posedge clk) disable iff (!rst_n)
    ctl_r.pvalid |-> (ctl_r.left != '0))
    else $error("pending transfer with zero count");

  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == S_EXEC))
    else $error("accepted item did not enter execute");

  a_out_from_exec: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r == S_EXEC))
    else $error("result shown without an executed item");

  a_release_flush: assert property (@(posedge clk) disable iff (!rst_n)
    (commit && res_step.bus_release) |=> !ctl_r.flushed)
    else $error("flushed mark kept after bus release");

endmodule
